// File: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, widths, register indexes and pipeline latencies of the
// environmental sensor compensation block
// ----------------------------------------------------------------------------
package esc_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_TEMP_CAL    = 3'd0;
  localparam logic [2:0] CFG_PRESS_CAL_A = 3'd1;
  localparam logic [2:0] CFG_PRESS_CAL_B = 3'd2;
  localparam logic [2:0] CFG_PRESS_CAL_C = 3'd3;
  localparam logic [2:0] CFG_HUM_CAL_A   = 3'd4;
  localparam logic [2:0] CFG_HUM_CAL_B   = 3'd5;

  // datapath widths
  localparam int TF_W   = 24;
  localparam int NUM_W  = 100;
  localparam int DEN_W  = 70;
  localparam int S_W    = 32;
  localparam int DIV_QW = 31;
  localparam int DIV_CW = (NUM_W > DEN_W + DIV_QW) ? NUM_W : DEN_W + DIV_QW;

  // pipeline latencies
  localparam int LAT_TEMP  = 4;
  localparam int LAT_PRE   = 7;
  localparam int LAT_DIV   = 34;
  localparam int LAT_POST  = 4;
  localparam int LAT_HUM   = 11;
  localparam int LAT_PRESS = LAT_PRE + LAT_DIV + LAT_POST;
  localparam int LAT_TOTAL = LAT_TEMP + LAT_PRESS;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [7:0]  h6;
    logic [11:0] h4;
    logic [11:0] h5;
  } cal_t;

  typedef struct packed {
    logic            vld;
    logic [TF_W-1:0] tf;
    logic [15:0]     tc;
    logic [19:0]     rp;
    logic [15:0]     rh;
  } temp_word_t;

  typedef struct packed {
    logic             vld;
    logic             dz;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_word_t;

  typedef struct packed {
    logic           vld;
    logic           dz;
    logic [S_W-1:0] s;
  } quo_word_t;

  typedef struct packed {
    logic        vld;
    logic        pvalid;
    logic [24:0] press;
  } press_word_t;

endpackage

// File: rtl/esc_temp.sv
// ----------------------------------------------------------------------------
// esc_temp
// temperature compensation pipeline: fine temperature and hundredths of degC
// ----------------------------------------------------------------------------
module esc_temp (
  input  logic                clk,
  input  logic                rst_n,
  input  esc_pkg::cal_t       cal,
  input  logic                in_vld,
  input  logic [19:0]         raw_temp,
  input  logic [19:0]         raw_press,
  input  logic [15:0]         raw_hum,
  output esc_pkg::temp_word_t tout
);

  localparam int NT_W = 58;

  logic               v1_r, v2_r, v3_r;
  logic signed [20:0] d_r;
  logic signed [36:0] m1_r;
  logic signed [41:0] dsq_r;
  logic signed [NT_W-1:0] n_r;
  logic [19:0] rp1_r, rp2_r, rp3_r;
  logic [15:0] rh1_r, rh2_r, rh3_r;
  esc_pkg::temp_word_t out_r;

  logic signed [20:0]     d_nxt;
  logic signed [36:0]     m1_nxt;
  logic signed [41:0]     dsq_nxt;
  logic signed [NT_W-1:0] m2_nxt;
  logic signed [NT_W-1:0] n_nxt;
  logic signed [NT_W-1:0] tf_sh;
  logic signed [NT_W-1:0] tf_full;
  logic signed [NT_W+2:0] n5;
  logic signed [NT_W+2:0] tc_sh;
  logic signed [NT_W+2:0] tc_full;
  logic [15:0]            tc_nxt;

  always_comb begin
    d_nxt   = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.t1, 4'b0000});
    m1_nxt  = d_r * $signed(cal.t2);
    dsq_nxt = d_r * d_r;
    m2_nxt  = dsq_r * $signed(cal.t3);
    n_nxt   = (NT_W'(m1_r) <<< 20) + m2_nxt;
    tf_sh   = n_r >>> 34;
    tf_full = tf_sh + NT_W'(n_r[NT_W-1] && (|n_r[33:0]));
    n5      = (NT_W+3)'(n_r) * 5;
    tc_sh   = n5 >>> 42;
    tc_full = tc_sh + (NT_W+3)'(n5[NT_W+2] && (|n5[41:0]));
    if (tc_full > 32767) begin
      tc_nxt = 16'h7fff;
    end else if (tc_full < -32768) begin
      tc_nxt = 16'h8000;
    end else begin
      tc_nxt = tc_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_r.vld <= 1'b0;
    end else begin
      v1_r      <= in_vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_r.vld <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    d_r      <= d_nxt;
    rp1_r    <= raw_press;
    rh1_r    <= raw_hum;
    m1_r     <= m1_nxt;
    dsq_r    <= dsq_nxt;
    rp2_r    <= rp1_r;
    rh2_r    <= rh1_r;
    n_r      <= n_nxt;
    rp3_r    <= rp2_r;
    rh3_r    <= rh2_r;
    out_r.tf <= tf_full[esc_pkg::TF_W-1:0];
    out_r.tc <= tc_nxt;
    out_r.rp <= rp3_r;
    out_r.rh <= rh3_r;
  end

  assign tout = out_r;

endmodule

// File: rtl/esc_ppre.sv
// ----------------------------------------------------------------------------
// esc_ppre
// pressure numerator and divisor pipeline ahead of the divider
// ----------------------------------------------------------------------------
module esc_ppre (
  input  logic                clk,
  input  logic                rst_n,
  input  esc_pkg::cal_t       cal,
  input  esc_pkg::temp_word_t tin,
  output esc_pkg::div_word_t  dout
);

  localparam int NW = esc_pkg::NUM_W;
  localparam int DW = esc_pkg::DEN_W;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [25:0] a_r;
  logic signed [51:0] aa_r;
  logic signed [41:0] ap5_r, ap2_r, ap5b_r, ap2b_r;
  logic signed [67:0] e1_r, dd1_r, e_r, dd_r, ph_r;
  logic signed [69:0] q_r;
  logic signed [51:0] dq_r;
  logic signed [DW-1:0] den_r;
  logic [60:0] pl_r;
  logic [19:0] rp1_r, rp2_r, rp3_r, rp4_r;
  esc_pkg::div_word_t out_r;

  logic signed [25:0] a_nxt;
  logic signed [51:0] aa_nxt;
  logic signed [41:0] ap5_nxt, ap2_nxt;
  logic signed [67:0] e1_nxt, dd1_nxt, e_nxt, dd_nxt, dd_sh, dq_full, ph_nxt;
  logic signed [21:0] qa;
  logic signed [69:0] q_nxt;
  logic signed [DW-1:0] den_nxt;
  logic signed [37:0] qh;
  logic [60:0] pl_nxt;
  logic signed [NW-1:0] num_nxt;

  always_comb begin
    a_nxt   = 26'($signed(tin.tf)) - 26'sd128000;
    aa_nxt  = a_r * a_r;
    ap5_nxt = a_r * $signed(cal.p5);
    ap2_nxt = a_r * $signed(cal.p2);
    e1_nxt  = aa_r * $signed(cal.p6);
    dd1_nxt = aa_r * $signed(cal.p3);
    e_nxt   = e1_r + (68'(ap5b_r) <<< 17) + (68'($signed(cal.p4)) <<< 35);
    dd_nxt  = (68'sd1 <<< 55) + dd1_r + (68'(ap2b_r) <<< 20);
    qa      = 22'sd1048576 - $signed({2'b00, rp4_r});
    q_nxt   = (70'(qa) <<< 31) - 70'(e_r);
    dd_sh   = dd_r >>> 16;
    dq_full = dd_sh + 68'(dd_r[67] && (|dd_r[15:0]));
    den_nxt = $signed({1'b0, cal.p1}) * dq_r;
    qh      = 38'(q_r >>> 32);
    ph_nxt  = qh * 30'sd409600000;
    pl_nxt  = q_r[31:0] * 29'd409600000;
    num_nxt = (NW'(ph_r) <<< 32) + NW'($signed({1'b0, pl_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      out_r.vld <= 1'b0;
    end else begin
      v1_r      <= tin.vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v6_r      <= v5_r;
      out_r.vld <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    rp1_r     <= tin.rp;
    aa_r      <= aa_nxt;
    ap5_r     <= ap5_nxt;
    ap2_r     <= ap2_nxt;
    rp2_r     <= rp1_r;
    e1_r      <= e1_nxt;
    dd1_r     <= dd1_nxt;
    ap5b_r    <= ap5_r;
    ap2b_r    <= ap2_r;
    rp3_r     <= rp2_r;
    e_r       <= e_nxt;
    dd_r      <= dd_nxt;
    rp4_r     <= rp3_r;
    q_r       <= q_nxt;
    dq_r      <= dq_full[51:0];
    den_r     <= den_nxt;
    ph_r      <= ph_nxt;
    pl_r      <= pl_nxt;
    out_r.num <= num_nxt;
    out_r.den <= den_r;
    out_r.dz  <= (den_r == '0);
  end

  assign dout = out_r;

endmodule

// File: rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// pipelined restoring divider, one quotient bit per stage, quotient
// truncated toward zero and saturated to 31 bits of magnitude
// ----------------------------------------------------------------------------
module esc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  esc_pkg::div_word_t din,
  output esc_pkg::quo_word_t qout
);

  localparam int NW = esc_pkg::NUM_W;
  localparam int DW = esc_pkg::DEN_W;
  localparam int QW = esc_pkg::DIV_QW;
  localparam int CW = esc_pkg::DIV_CW;

  logic          v0_r, neg0_r, dz0_r;
  logic [NW-1:0] nm0_r;
  logic [DW-1:0] dm0_r;

  logic          vld_r [0:QW];
  logic          neg_r [0:QW];
  logic          dz_r  [0:QW];
  logic          ovf_r [0:QW];
  logic [QW-1:0] quo_r [0:QW];
  logic [CW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] dm_r  [0:QW-1];

  esc_pkg::quo_word_t out_r;

  logic [NW-1:0] nm_nxt;
  logic [DW-1:0] dm_nxt;
  logic [QW-1:0] qv;
  logic [QW:0]   qe;

  always_comb begin
    nm_nxt = din.num[NW-1] ? (~din.num + NW'(1)) : din.num;
    dm_nxt = din.den[DW-1] ? (~din.den + DW'(1)) : din.den;
    qv     = ovf_r[QW] ? '1 : quo_r[QW];
    qe     = {1'b0, qv};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r     <= 1'b0;
      vld_r[0] <= 1'b0;
    end else begin
      v0_r     <= din.vld;
      vld_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    nm0_r    <= nm_nxt;
    dm0_r    <= dm_nxt;
    neg0_r   <= din.num[NW-1] ^ din.den[DW-1];
    dz0_r    <= din.dz;
    rem_r[0] <= CW'(nm0_r);
    dm_r[0]  <= dm0_r;
    neg_r[0] <= neg0_r;
    dz_r[0]  <= dz0_r;
    ovf_r[0] <= CW'(nm0_r) >= (CW'(dm0_r) << QW);
    quo_r[0] <= '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [CW-1:0] sh;
    logic          ge;
    assign sh = CW'(dm_r[j]) << (QW - 1 - j);
    assign ge = rem_r[j] >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      neg_r[j+1] <= neg_r[j];
      dz_r[j+1]  <= dz_r[j];
      ovf_r[j+1] <= ovf_r[j];
      quo_r[j+1] <= {quo_r[j][QW-2:0], ge};
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[j+1] <= ge ? (rem_r[j] - sh) : rem_r[j];
        dm_r[j+1]  <= dm_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.vld <= 1'b0;
    end else begin
      out_r.vld <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    out_r.dz <= dz_r[QW];
    out_r.s  <= neg_r[QW] ? (~qe + esc_pkg::S_W'(1)) : qe;
  end

  assign qout = out_r;

endmodule

// File: rtl/esc_ppost.sv
// ----------------------------------------------------------------------------
// esc_ppost
// second-order pressure correction and output saturation
// ----------------------------------------------------------------------------
module esc_ppost (
  input  logic                 clk,
  input  logic                 rst_n,
  input  esc_pkg::cal_t        cal,
  input  esc_pkg::quo_word_t   qin,
  output esc_pkg::press_word_t pout
);

  logic v1_r, v2_r, v3_r;
  logic dz1_r, dz2_r, dz3_r;
  logic signed [31:0] s1_r, s2_r, s3_r;
  logic signed [63:0] ss_r;
  logic signed [47:0] p8s_r, p8s2_r;
  logic signed [79:0] t9_r;
  logic signed [81:0] acc_r;
  esc_pkg::press_word_t out_r;

  logic signed [63:0] ss_nxt;
  logic signed [47:0] p8s_nxt;
  logic signed [79:0] t9_nxt;
  logic signed [81:0] acc_nxt, c_sh, c_full;
  logic signed [39:0] sum;
  logic [24:0]        pr_nxt;

  always_comb begin
    ss_nxt  = $signed(qin.s) * $signed(qin.s);
    p8s_nxt = $signed(qin.s) * $signed(cal.p8);
    t9_nxt  = ss_r * $signed(cal.p9);
    acc_nxt = 82'(t9_r) + (82'(p8s2_r) <<< 24) + (82'($signed(cal.p7)) <<< 47);
    c_sh    = acc_r >>> 43;
    c_full  = c_sh + 82'(acc_r[81] && (|acc_r[42:0]));
    sum     = 40'(s3_r) + 40'(c_full);
    if (dz3_r || sum < 0) begin
      pr_nxt = '0;
    end else if (sum > 40'sd33554431) begin
      pr_nxt = '1;
    end else begin
      pr_nxt = sum[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      out_r.vld <= 1'b0;
    end else begin
      v1_r      <= qin.vld;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      out_r.vld <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ss_r         <= ss_nxt;
    p8s_r        <= p8s_nxt;
    s1_r         <= qin.s;
    dz1_r        <= qin.dz;
    t9_r         <= t9_nxt;
    p8s2_r       <= p8s_r;
    s2_r         <= s1_r;
    dz2_r        <= dz1_r;
    acc_r        <= acc_nxt;
    s3_r         <= s2_r;
    dz3_r        <= dz2_r;
    out_r.press  <= pr_nxt;
    out_r.pvalid <= !dz3_r;
  end

  assign pout = out_r;

endmodule

// File: rtl/esc_hum.sv
// ----------------------------------------------------------------------------
// esc_hum
// humidity compensation pipeline, result in 1/1024 percent clamped to 0..100
// ----------------------------------------------------------------------------
module esc_hum (
  input  logic                clk,
  input  esc_pkg::cal_t       cal,
  input  esc_pkg::temp_word_t tin,
  output logic [16:0]         hum
);

  logic signed [25:0]  h0_r;
  logic [15:0]         rh1_r, rh2_r;
  logic signed [37:0]  h5_r;
  logic signed [34:0]  h3_r;
  logic signed [33:0]  h6_r, h6b_r;
  logic signed [39:0]  an_r;
  logic signed [35:0]  b1_r;
  logic signed [55:0]  x_r, x2_r;
  logic signed [69:0]  bp_r;
  logic signed [71:0]  bn_r;
  logic signed [51:0]  phh_r;
  logic signed [54:0]  phl_r;
  logic signed [58:0]  plh_r;
  logic signed [61:0]  pll_r;
  logic signed [129:0] p_r;
  logic signed [31:0]  hq_r, hq2_r;
  logic signed [40:0]  g_r;
  logic signed [74:0]  hp_r;
  logic [16:0]         hum_r;

  logic signed [25:0]  h0_nxt;
  logic signed [37:0]  h5_nxt;
  logic signed [34:0]  h3_nxt;
  logic signed [33:0]  h6_nxt;
  logic signed [39:0]  an_nxt;
  logic signed [35:0]  b1_nxt;
  logic signed [55:0]  x_nxt;
  logic signed [69:0]  bp_nxt;
  logic signed [71:0]  bn_nxt;
  logic signed [21:0]  xh;
  logic signed [28:0]  xl;
  logic signed [29:0]  bh;
  logic signed [32:0]  bl;
  logic signed [51:0]  phh_nxt;
  logic signed [54:0]  phl_nxt;
  logic signed [58:0]  plh_nxt;
  logic signed [61:0]  pll_nxt;
  logic signed [129:0] p_nxt, hq_sh, hq_full;
  logic signed [31:0]  hq_nxt;
  logic signed [40:0]  g_nxt;
  logic signed [42:0]  w;
  logic signed [74:0]  hp_nxt, hm_sh, hm_full;
  logic [16:0]         hum_nxt;

  always_comb begin
    h0_nxt  = 26'($signed(tin.tf)) - 26'sd76800;
    h5_nxt  = h0_r * $signed(cal.h5);
    h3_nxt  = h0_r * $signed({1'b0, cal.h3});
    h6_nxt  = h0_r * $signed(cal.h6);
    an_nxt  = 40'($signed({1'b0, rh2_r, 14'b0})) - (40'($signed(cal.h4)) <<< 20) - 40'(h5_r);
    b1_nxt  = (36'sd1 <<< 26) + 36'(h3_r);
    x_nxt   = an_r * $signed(cal.h2);
    bp_nxt  = h6b_r * b1_r;
    bn_nxt  = (72'sd1 <<< 52) + 72'(bp_r);
    // split both factors so each partial product stays near 32 by 32
    xh      = 22'(x2_r >>> 28);
    xl      = $signed({1'b0, x2_r[27:0]});
    bh      = 30'(bn_r >>> 32);
    bl      = $signed({1'b0, bn_r[31:0]});
    phh_nxt = xh * bh;
    phl_nxt = xh * bl;
    plh_nxt = xl * bh;
    pll_nxt = xl * bl;
    p_nxt   = (130'(phh_r) <<< 60) + (130'(phl_r) <<< 28) + (130'(plh_r) <<< 32)
            + 130'(pll_r);
    hq_sh   = p_r >>> 72;
    hq_full = hq_sh + 130'(p_r[129] && (|p_r[71:0]));
    if (hq_full > 130'sd2147483647) begin
      hq_nxt = 32'sd2147483647;
    end else if (hq_full < -130'sd2147483647) begin
      hq_nxt = -32'sd2147483647;
    end else begin
      hq_nxt = hq_full[31:0];
    end
    g_nxt   = hq_r * $signed({1'b0, cal.h1});
    w       = (43'sd1 <<< 29) - 43'(g_r);
    hp_nxt  = hq2_r * w;
    hm_sh   = hp_r >>> 29;
    hm_full = hm_sh + 75'(hp_r[74] && (|hp_r[28:0]));
    if (hm_full < 0) begin
      hum_nxt = '0;
    end else if (hm_full > 75'sd102400) begin
      hum_nxt = 17'd102400;
    end else begin
      hum_nxt = hm_full[16:0];
    end
  end

  always_ff @(posedge clk) begin
    h0_r  <= h0_nxt;
    rh1_r <= tin.rh;
    h5_r  <= h5_nxt;
    h3_r  <= h3_nxt;
    h6_r  <= h6_nxt;
    rh2_r <= rh1_r;
    an_r  <= an_nxt;
    b1_r  <= b1_nxt;
    h6b_r <= h6_r;
    x_r   <= x_nxt;
    bp_r  <= bp_nxt;
    bn_r  <= bn_nxt;
    x2_r  <= x_r;
    phh_r <= phh_nxt;
    phl_r <= phl_nxt;
    plh_r <= plh_nxt;
    pll_r <= pll_nxt;
    p_r   <= p_nxt;
    hq_r  <= hq_nxt;
    g_r   <= g_nxt;
    hq2_r <= hq_r;
    hp_r  <= hp_nxt;
    hum_r <= hum_nxt;
  end

  assign hum = hum_r;

endmodule

// File: rtl/env_sensor_compensation.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation
// compensated temperature, pressure and humidity from one raw sensor sample
// ----------------------------------------------------------------------------
// A raw sample is taken at every clock edge where start is high; busy is
// always low, so one word per cycle is accepted. Each result is marked by
// out_valid for exactly one cycle; the receiver cannot hold it off, so it
// must capture the word on that cycle. The latency is set mainly by the
// pressure divider, a 31-stage restoring pipeline that resolves one
// quotient bit per stage; temperature and humidity are delayed to line up
// with pressure. Calibration registers are to be written only while no
// sample is in flight.
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] in_raw_temp,
  input  logic [19:0] in_raw_press,
  input  logic [15:0] in_raw_hum,
  output logic        out_valid,
  output logic [15:0] out_temp_centi,
  output logic [24:0] out_press_q8,
  output logic        out_press_valid,
  output logic [16:0] out_hum_q10,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_wdata
);

  localparam int HUM_DLY = esc_pkg::LAT_PRESS - esc_pkg::LAT_HUM;
  localparam int TC_DLY  = esc_pkg::LAT_PRESS;

  logic [47:0] temp_cal_r;
  logic [63:0] press_cal_a_r;
  logic [63:0] press_cal_b_r;
  logic [15:0] press_cal_c_r;
  logic [39:0] hum_cal_a_r;
  logic [23:0] hum_cal_b_r;

  esc_pkg::cal_t        cal;
  esc_pkg::temp_word_t  tword;
  esc_pkg::div_word_t   dword;
  esc_pkg::quo_word_t   qword;
  esc_pkg::press_word_t pword;
  logic [16:0]          hum;

  logic [15:0] tc_line_r  [0:TC_DLY-1];
  logic [16:0] hum_line_r [0:HUM_DLY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      press_cal_c_r <= '0;
      hum_cal_a_r   <= '0;
      hum_cal_b_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        esc_pkg::CFG_TEMP_CAL:    temp_cal_r    <= cfg_wdata[47:0];
        esc_pkg::CFG_PRESS_CAL_A: press_cal_a_r <= cfg_wdata;
        esc_pkg::CFG_PRESS_CAL_B: press_cal_b_r <= cfg_wdata;
        esc_pkg::CFG_PRESS_CAL_C: press_cal_c_r <= cfg_wdata[15:0];
        esc_pkg::CFG_HUM_CAL_A:   hum_cal_a_r   <= cfg_wdata[39:0];
        esc_pkg::CFG_HUM_CAL_B:   hum_cal_b_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_cal_a_r[15:0];
    cal.p2 = press_cal_a_r[31:16];
    cal.p3 = press_cal_a_r[47:32];
    cal.p4 = press_cal_a_r[63:48];
    cal.p5 = press_cal_b_r[15:0];
    cal.p6 = press_cal_b_r[31:16];
    cal.p7 = press_cal_b_r[47:32];
    cal.p8 = press_cal_b_r[63:48];
    cal.p9 = press_cal_c_r;
    cal.h1 = hum_cal_a_r[7:0];
    cal.h2 = hum_cal_a_r[23:8];
    cal.h3 = hum_cal_a_r[31:24];
    cal.h6 = hum_cal_a_r[39:32];
    cal.h4 = hum_cal_b_r[11:0];
    cal.h5 = hum_cal_b_r[23:12];
  end

  assign busy = 1'b0;

  esc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cal       (cal),
    .in_vld    (start && !busy),
    .raw_temp  (in_raw_temp),
    .raw_press (in_raw_press),
    .raw_hum   (in_raw_hum),
    .tout      (tword)
  );

  esc_ppre u_ppre (
    .clk   (clk),
    .rst_n (rst_n),
    .cal   (cal),
    .tin   (tword),
    .dout  (dword)
  );

  esc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .din   (dword),
    .qout  (qword)
  );

  esc_ppost u_ppost (
    .clk   (clk),
    .rst_n (rst_n),
    .cal   (cal),
    .qin   (qword),
    .pout  (pword)
  );

  esc_hum u_hum (
    .clk (clk),
    .cal (cal),
    .tin (tword),
    .hum (hum)
  );

  always_ff @(posedge clk) begin
    tc_line_r[0]  <= tword.tc;
    hum_line_r[0] <= hum;
    for (int i = 1; i < TC_DLY; i++) begin
      tc_line_r[i] <= tc_line_r[i-1];
    end
    for (int i = 1; i < HUM_DLY; i++) begin
      hum_line_r[i] <= hum_line_r[i-1];
    end
  end

  assign out_valid       = pword.vld;
  assign out_press_q8    = pword.press;
  assign out_press_valid = pword.pvalid;
  assign out_temp_centi  = tc_line_r[TC_DLY-1];
  assign out_hum_q10     = hum_line_r[HUM_DLY-1];

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(esc_pkg::LAT_TOTAL) out_valid)
    else $error("sample did not come out after the pipeline latency");

  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_press_valid) |-> (out_press_q8 == '0))
    else $error("pressure not zero on divisor zero");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hum_q10 <= 17'd102400))
    else $error("humidity above full scale");
`endif

endmodule
